>>> hdl/dtt_pkg.sv
package dtt_pkg;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int INT_W  = 31;
    localparam int FRAC_W = 30;

    localparam logic [INT_W-1:0]  INT_MAX_MAG = 31'h7FFF_FFFF;
    localparam logic [FRAC_W-1:0] DEC_SCALE   = 30'd1_000_000_000;
    localparam logic [FRAC_W-1:0] DEC_HALF    = 30'd500_000_000;

    typedef enum logic [1:0] {
        PH_DONE = 2'd0,
        PH_INT  = 2'd1,
        PH_FRAC = 2'd2
    } phase_t;

    typedef struct packed {
        logic             negative;
        logic             overflowed;
        logic [INT_W-1:0] int_mag;
    } num_t;

    // weight of the fraction digit at position k, padded to nine digits
    function automatic logic [FRAC_W-1:0] frac_weight(input logic [3:0] k);
        logic [FRAC_W-1:0] w;
        unique case (k)
            4'd0:    w = 30'd100_000_000;
            4'd1:    w = 30'd10_000_000;
            4'd2:    w = 30'd1_000_000;
            4'd3:    w = 30'd100_000;
            4'd4:    w = 30'd10_000;
            4'd5:    w = 30'd1_000;
            4'd6:    w = 30'd100;
            4'd7:    w = 30'd10;
            4'd8:    w = 30'd1;
            default: w = 30'd0;
        endcase
        return w;
    endfunction

endpackage

>>> hdl/decimal_text_to_fixed_point_top.sv
// Channel   Dir  tdata                       tuser
// s_        in   [7:0] ch                    [0] first
// m_        out  [63:0] value (Q31.FRAC_BITS) [0] saturated
// cfg_wr_*  in   [0] fraction_enable         -
//
// One character accepted per cycle while m_ is not stalled; the parse state updates in that cycle.
// After its ending character is taken, a result passes through these registers to m_:
// four divider registers turn the decimal fraction into binary by reciprocal
// multiply and correction, then the rounding register and the output register.
// Synchronous active-low reset; no character is taken while aresetn is low.
// A stalled m_ side freezes the whole pipeline and drops s_tready.
module decimal_text_to_fixed_point_top #(
    parameter int MAX_FRAC_DIGITS = 9,
    parameter int FRAC_BITS       = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic [0:0]  s_tuser,   // [0] first
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] value
    output logic [0:0]  m_tuser    // [0] saturated
);
    import dtt_pkg::*;

    logic                 frac_en_reg;
    logic                 en;
    logic                 accept;

    logic                 req_valid;
    num_t                 req_num;
    logic [FRAC_W-1:0]    req_frac;

    logic                 div_valid;
    num_t                 div_num;
    logic [FRAC_W-1:0]    div_rem;
    logic [FRAC_BITS-1:0] div_quo;

    logic                 res_sat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frac_en_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            frac_en_reg <= cfg_wr_data;
        end
    end

    assign en       = !m_tvalid || m_tready;
    assign s_tready = aresetn && en;
    assign accept   = s_tvalid && s_tready;

    dtt_parser #(
        .MAX_FRAC_DIGITS(MAX_FRAC_DIGITS)
    ) u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .frac_en  (frac_en_reg),
        .accept   (accept),
        .ch       (s_tdata),
        .first    (s_tuser[0]),
        .req_valid(req_valid),
        .req_num  (req_num),
        .req_frac (req_frac)
    );

    dtt_div_pipe #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (req_valid),
        .in_num   (req_num),
        .in_frac  (req_frac),
        .out_valid(div_valid),
        .out_num  (div_num),
        .out_rem  (div_rem),
        .out_quo  (div_quo)
    );

    dtt_result #(
        .FRAC_BITS(FRAC_BITS)
    ) u_result (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (div_valid),
        .in_num   (div_num),
        .in_rem   (div_rem),
        .in_quo   (div_quo),
        .out_valid(m_tvalid),
        .out_value(m_tdata),
        .out_sat  (res_sat)
    );

    assign m_tuser = res_sat;

endmodule

>>> hdl/dtt_parser.sv
module dtt_parser #(
    parameter int MAX_FRAC_DIGITS = 9
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       frac_en,
    input  logic                       accept,
    input  logic [7:0]                 ch,
    input  logic                       first,
    output logic                       req_valid,
    output dtt_pkg::num_t              req_num,
    output logic [dtt_pkg::FRAC_W-1:0] req_frac
);
    import dtt_pkg::*;

    localparam int DIG_W = $clog2(MAX_FRAC_DIGITS + 1);
    localparam logic [DIG_W-1:0] DIG_MAX = DIG_W'(MAX_FRAC_DIGITS);

    phase_t            phase_reg, phase_next, phase_eff;
    num_t              num_reg, num_next, num_eff;
    logic [FRAC_W-1:0] frac_reg, frac_next, frac_eff;
    logic [DIG_W-1:0]  cnt_reg, cnt_next, cnt_eff;

    logic              is_digit;
    logic [3:0]        dval;
    logic [34:0]       int_prod;
    logic [33:0]       frac_term;

    assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign dval      = ch[3:0];
    assign int_prod  = 35'(num_eff.int_mag) * 35'd10 + 35'(dval);
    assign frac_term = 34'(dval) * 34'(frac_weight(4'(cnt_eff)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_DONE;
            num_reg   <= '0;
            frac_reg  <= '0;
            cnt_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            num_reg   <= num_next;
            frac_reg  <= frac_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        if (first) begin
            phase_eff = PH_INT;
            num_eff   = '0;
            frac_eff  = '0;
            cnt_eff   = '0;
        end else begin
            phase_eff = phase_reg;
            num_eff   = num_reg;
            frac_eff  = frac_reg;
            cnt_eff   = cnt_reg;
        end

        phase_next = phase_reg;
        num_next   = num_reg;
        frac_next  = frac_reg;
        cnt_next   = cnt_reg;
        req_valid  = 1'b0;

        if (accept) begin
            phase_next = phase_eff;
            num_next   = num_eff;
            frac_next  = frac_eff;
            cnt_next   = cnt_eff;
            priority if (first && ch == CH_MINUS) begin
                num_next.negative = 1'b1;
            end else if (first && ch == CH_PLUS) begin
                num_next.negative = 1'b0;
            end else if (phase_eff == PH_INT) begin
                priority if (is_digit) begin
                    if (!num_eff.overflowed) begin
                        if (int_prod > 35'(INT_MAX_MAG)) begin
                            num_next.overflowed = 1'b1;
                            num_next.int_mag    = INT_MAX_MAG;
                        end else begin
                            num_next.int_mag = int_prod[INT_W-1:0];
                        end
                    end
                end else if (ch == CH_DOT && frac_en) begin
                    phase_next = PH_FRAC;
                end else begin
                    req_valid  = 1'b1;
                    phase_next = PH_DONE;
                end
            end else if (phase_eff == PH_FRAC) begin
                if (is_digit) begin
                    if (cnt_eff < DIG_MAX) begin
                        frac_next = frac_eff + frac_term[FRAC_W-1:0];
                        cnt_next  = cnt_eff + DIG_W'(1);
                    end
                end else begin
                    req_valid  = 1'b1;
                    phase_next = PH_DONE;
                end
            end else begin
                phase_next = PH_DONE;
            end
        end
    end

    assign req_num  = num_eff;
    assign req_frac = frac_eff;

    a_sign_opens: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && first && ch == CH_MINUS |=> phase_reg == PH_INT && num_reg.negative)
        else $error("minus sign did not open a negative number");

    a_end_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        req_valid |=> phase_reg == PH_DONE)
        else $error("number still open after its end");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= DIG_MAX)
        else $error("fraction digit count past limit");

    a_frac_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        frac_reg < DEC_SCALE)
        else $error("padded fraction out of range");

endmodule

>>> hdl/dtt_div_pipe.sv
module dtt_div_pipe #(
    parameter int FRAC_BITS = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  dtt_pkg::num_t              in_num,
    input  logic [dtt_pkg::FRAC_W-1:0] in_frac,
    output logic                       out_valid,
    output dtt_pkg::num_t              out_num,
    output logic [dtt_pkg::FRAC_W-1:0] out_rem,
    output logic [FRAC_BITS-1:0]       out_quo
);
    import dtt_pkg::*;

    localparam int PROD_W = FRAC_W + FRAC_BITS + 1;
    localparam int REM_W  = FRAC_W + 1;
    localparam logic [FRAC_BITS:0] RECIP =
        (FRAC_BITS+1)'((64'd1 << (FRAC_BITS + FRAC_W)) / 64'(DEC_SCALE));
    localparam logic [REM_W-1:0] SCALE_X = {1'b0, DEC_SCALE};

    logic                 valid0_reg, valid1_reg, valid2_reg, valid3_reg;
    num_t                 num0_reg, num1_reg, num2_reg, num3_reg;
    logic [FRAC_W-1:0]    frac0_reg, frac1_reg;
    logic [FRAC_BITS-1:0] quo1_reg, quo2_reg, quo3_reg;
    logic [REM_W-1:0]     rem2_reg;
    logic [FRAC_W-1:0]    rem3_reg;

    logic [PROD_W-1:0]    prod;
    logic [REM_W-1:0]     back_lo;
    logic [REM_W-1:0]     rem2_next;
    logic                 ge;
    logic [FRAC_W-1:0]    rem3_next;
    logic [FRAC_BITS-1:0] quo3_next;

    always_comb begin
        prod      = PROD_W'(frac0_reg) * PROD_W'(RECIP);
        back_lo   = REM_W'(quo1_reg) * REM_W'(DEC_SCALE);
        rem2_next = REM_W'({frac1_reg, {FRAC_BITS{1'b0}}}) - back_lo;
        ge        = rem2_reg >= SCALE_X;
        rem3_next = ge ? FRAC_W'(rem2_reg - SCALE_X) : rem2_reg[FRAC_W-1:0];
        quo3_next = quo2_reg + FRAC_BITS'(ge);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid0_reg <= 1'b0;
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end else if (en) begin
            valid0_reg <= in_valid;
            valid1_reg <= valid0_reg;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num0_reg  <= in_num;
            frac0_reg <= in_frac;
            num1_reg  <= num0_reg;
            frac1_reg <= frac0_reg;
            quo1_reg  <= prod[FRAC_W +: FRAC_BITS];
            num2_reg  <= num1_reg;
            quo2_reg  <= quo1_reg;
            rem2_reg  <= rem2_next;
            num3_reg  <= num2_reg;
            quo3_reg  <= quo3_next;
            rem3_reg  <= rem3_next;
        end
    end

    assign out_valid = valid3_reg;
    assign out_num   = num3_reg;
    assign out_rem   = rem3_reg;
    assign out_quo   = quo3_reg;

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        valid3_reg |-> rem3_reg < DEC_SCALE)
        else $error("division remainder out of range");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(valid3_reg))
        else $error("pipeline moved while stalled");

    a_input_travel: assert property (@(posedge aclk) disable iff (!aresetn)
        en && in_valid |=> valid0_reg)
        else $error("request lost entering the divider");

endmodule

>>> hdl/dtt_result.sv
module dtt_result #(
    parameter int FRAC_BITS = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  dtt_pkg::num_t              in_num,
    input  logic [dtt_pkg::FRAC_W-1:0] in_rem,
    input  logic [FRAC_BITS-1:0]       in_quo,
    output logic                       out_valid,
    output logic [63:0]                out_value,
    output logic                       out_sat
);
    import dtt_pkg::*;

    localparam int MAG_W = INT_W + FRAC_BITS;
    localparam logic [MAG_W-1:0] MAX_MAG = {MAG_W{1'b1}};

    logic [FRAC_BITS:0]  quo_rnd;
    logic [MAG_W:0]      mag_sum;
    logic [MAG_W-1:0]    mag_next;
    logic                sat_next;

    logic                rnd_valid_reg;
    logic [MAG_W-1:0]    rnd_mag_reg;
    logic                rnd_sat_reg;
    logic                rnd_neg_reg;

    logic                out_valid_reg;
    logic [63:0]         out_value_reg, out_value_next;
    logic                out_sat_reg;

    always_comb begin
        quo_rnd  = {1'b0, in_quo} + (FRAC_BITS+1)'(in_rem >= DEC_HALF);
        mag_sum  = {1'b0, in_num.int_mag, {FRAC_BITS{1'b0}}} + (MAG_W+1)'(quo_rnd);
        sat_next = in_num.overflowed || mag_sum[MAG_W];
        mag_next = sat_next ? MAX_MAG : mag_sum[MAG_W-1:0];
    end

    assign out_value_next = rnd_neg_reg ? (64'd0 - 64'(rnd_mag_reg)) : 64'(rnd_mag_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rnd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            rnd_valid_reg <= in_valid;
            out_valid_reg <= rnd_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rnd_mag_reg   <= mag_next;
            rnd_sat_reg   <= sat_next;
            rnd_neg_reg   <= in_num.negative;
            out_value_reg <= out_value_next;
            out_sat_reg   <= rnd_sat_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_sat   = out_sat_reg;

    a_sat_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_sat_reg |->
            out_value_reg == 64'(MAX_MAG) || out_value_reg == 64'd0 - 64'(MAX_MAG))
        else $error("saturated result not at full scale");

    a_ovf_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        en && in_valid && in_num.overflowed |=> rnd_valid_reg && rnd_sat_reg)
        else $error("integer overflow not flagged");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_value_reg[63] == out_value_reg[MAG_W] ||
            out_value_reg == 64'd0)
        else $error("result outside Q format range");

endmodule

>>> tb/sv/fixed_point_checker.sv
module fixed_point_checker #(
    parameter int MAX_FRAC_DIGITS = 9,
    parameter int FRAC_BITS       = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic [0:0]  s_tuser,   // [0] first
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,   // [63:0] value
    input  logic [0:0]  m_tuser,   // [0] saturated
    output int          fail_count,
    output int          exp_pending
);
    import dtt_pkg::*;

    localparam logic [63:0] MAX_MAG   = (64'd1 << (31 + FRAC_BITS)) - 64'd1;
    localparam logic [63:0] INT_LIMIT = 64'(INT_MAX_MAG);

    typedef struct packed {
        logic [63:0] value;
        logic        saturated;
    } fixed_result_t;

    fixed_result_t expected_fixed_q[$];

    phase_t      phase;
    logic        neg;
    logic        ovf;
    logic        frac_en;
    logic [63:0] int_sum;
    logic [63:0] frac_sum;
    int          frac_cnt;

    task automatic parse_char(input logic [7:0] ch, input logic first);
        logic        is_digit;
        logic        ends;
        logic        sat;
        logic [63:0] d;
        logic [63:0] t;
        logic [63:0] div;
        logic [63:0] frac;
        logic [63:0] mag;
        is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
        d = {60'd0, ch[3:0]};
        ends = 1'b0;
        if (first) begin
            neg      = 1'b0;
            ovf      = 1'b0;
            int_sum  = 64'd0;
            frac_sum = 64'd0;
            frac_cnt = 0;
            phase    = PH_INT;
        end
        if (first && (ch == CH_MINUS || ch == CH_PLUS)) begin
            neg = (ch == CH_MINUS);
        end else if (phase == PH_INT) begin
            if (is_digit) begin
                if (!ovf) begin
                    t = int_sum * 64'd10 + d;
                    if (t > INT_LIMIT) begin
                        ovf     = 1'b1;
                        int_sum = INT_LIMIT;
                    end else begin
                        int_sum = t;
                    end
                end
            end else if (ch == CH_DOT && frac_en) begin
                phase = PH_FRAC;
            end else begin
                ends = 1'b1;
            end
        end else if (phase == PH_FRAC) begin
            if (is_digit) begin
                if (frac_cnt < MAX_FRAC_DIGITS) begin
                    frac_sum = frac_sum * 64'd10 + d;
                    frac_cnt++;
                end
            end else begin
                ends = 1'b1;
            end
        end
        if (ends) begin
            if (ovf) begin
                mag = MAX_MAG;
                sat = 1'b1;
            end else begin
                div  = 64'd1;
                frac = 64'd0;
                repeat (frac_cnt) div = div * 64'd10;
                if (frac_cnt > 0) begin
                    frac = ((frac_sum << FRAC_BITS) + div / 64'd2) / div;
                end
                mag = (int_sum << FRAC_BITS) + frac;
                sat = 1'b0;
                if (mag > MAX_MAG) begin
                    mag = MAX_MAG;
                    sat = 1'b1;
                end
            end
            expected_fixed_q.push_back('{value: neg ? 64'd0 - mag : mag, saturated: sat});
            phase = PH_DONE;
        end
    endtask

    always @(posedge aclk) begin
        fixed_result_t want;
        if (!aresetn) begin
            phase      = PH_DONE;
            neg        = 1'b0;
            ovf        = 1'b0;
            int_sum    = 64'd0;
            frac_sum   = 64'd0;
            frac_cnt   = 0;
            frac_en    = 1'b1;
            fail_count = 0;
            expected_fixed_q.delete();
        end else begin
            if (cfg_wr_en) begin
                frac_en = cfg_wr_data;
            end
            if (m_tvalid && m_tready) begin
                if (expected_fixed_q.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("unexpected result: value %h saturated %b",
                                 m_tdata, m_tuser[0]);
                    end
                    fail_count++;
                end else begin
                    want = expected_fixed_q.pop_front();
                    if (m_tdata !== want.value || m_tuser[0] !== want.saturated) begin
                        if (fail_count < 10) begin
                            $display("mismatch: value exp %h got %h, saturated exp %b got %b",
                                     want.value, m_tdata, want.saturated, m_tuser[0]);
                        end
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                parse_char(s_tdata, s_tuser[0]);
            end
        end
        exp_pending = expected_fixed_q.size();
    end

endmodule

>>> tb/sv/testbench.sv
module testbench;
    import dtt_pkg::*;

    localparam int MAX_FRAC_DIGITS = 9;
    localparam int FRAC_BITS       = 32;
    localparam int DRAIN_CYCLES    = FRAC_BITS + 3 + 20;
    localparam int HOLD_CYCLES     = 400;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int N_RANDOM        = 500;
    localparam int N_PHASES        = 5;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic [7:0]  s_tdata     = 8'd0;
    logic [0:0]  s_tuser     = 1'b0;
    logic        m_tready    = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [63:0] m_tdata;
    logic [0:0]  m_tuser;

    logic hold_req    = 1'b0;
    int   burst_left  = 0;
    int   idle_cycles = 0;
    int   n_items     = 0;
    int   fail_count;
    int   exp_pending;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    decimal_text_to_fixed_point_top #(
        .MAX_FRAC_DIGITS(MAX_FRAC_DIGITS),
        .FRAC_BITS      (FRAC_BITS)
    ) uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    fixed_point_checker #(
        .MAX_FRAC_DIGITS(MAX_FRAC_DIGITS),
        .FRAC_BITS      (FRAC_BITS)
    ) chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .exp_pending(exp_pending)
    );

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int hold_cnt;
        int mode;
        int mode_left;
        int tick;
        hold_cnt  = 0;
        mode      = 0;
        mode_left = 0;
        tick      = 0;
        forever begin
            @(negedge aclk);
            tick++;
            if (hold_req) begin
                hold_req = 1'b0;
                hold_cnt = HOLD_CYCLES;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end else begin
                    mode_left--;
                end
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ((tick % 6) < 3);
                endcase
            end
        end
    end

    task automatic push_item(input logic [7:0] ch, input logic first);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tuser  <= first;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        burst_left--;
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) begin
            push_item(txt[i], i == 0);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(negedge aclk); while (exp_pending != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_fraction_enable(input logic en);
        // hold a number open across the write
        push_item(CH_ZERO + 8'($urandom_range(1, 9)), 1'b1);
        n_items += 1;
        if ($urandom_range(0, 1) == 1) begin
            push_item(CH_DOT, 1'b0);
            n_items += 1;
        end
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= en;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        push_item(CH_ZERO + 8'd5, 1'b0);
        push_item(CH_DOT, 1'b0);
        push_item(CH_ZERO + 8'd5, 1'b0);
        push_item(8'h3B, 1'b0);
        n_items += 4;
    endtask

    task automatic send_random_number();
        logic [7:0] seq[$];
        logic [7:0] c;
        string      head;
        int         kind;
        int         n;
        kind = $urandom_range(0, 99);
        head = "";
        if (kind < 5) begin
            n = $urandom_range(1, 6);
            repeat (n) begin
                push_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
            n_items += n;
            return;
        end
        case ($urandom_range(0, 9))
            0, 1, 2: seq.push_back(CH_MINUS);
            3:       seq.push_back(CH_PLUS);
            default: ;
        endcase
        if (kind < 11) begin
            head = "2147483647";
        end else if (kind < 17) begin
            head = "214748364";
        end
        for (int i = 0; i < head.len(); i++) begin
            seq.push_back(head[i]);
        end
        if (kind >= 11 && kind < 17) begin
            seq.push_back(8'h38 + 8'($urandom_range(0, 1)));
            n = $urandom_range(0, 3);
        end else if (kind >= 17) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 10) : $urandom_range(0, 4);
        end else begin
            n = 0;
        end
        repeat (n) seq.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        if (kind < 11 || $urandom_range(0, 2) != 0) begin
            seq.push_back(CH_DOT);
            if (kind < 11) begin
                n = $urandom_range(9, 11);
            end else begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 5);
            end
            repeat (n) begin
                seq.push_back(kind < 11 ? CH_NINE : CH_ZERO + 8'($urandom_range(0, 9)));
            end
        end
        case ($urandom_range(0, 19))
            0:       ;
            1:       seq.push_back(CH_DOT);
            default: begin
                do c = 8'($urandom_range(0, 255)); while (c >= CH_ZERO && c <= CH_NINE);
                seq.push_back(c);
            end
        endcase
        if (seq.size() == 0) begin
            seq.push_back(8'($urandom_range(0, 255)));
        end
        foreach (seq[i]) begin
            push_item(seq[i], i == 0);
        end
        n_items += seq.size();
        if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 3);
            repeat (n) push_item(8'($urandom_range(0, 255)), 1'b0);
            n_items += n;
        end
    endtask

    initial begin
        int phase_end;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_text("-3.14159265358979;");
        send_text("+.,");
        push_item(8'hFF, 1'b1);
        push_item(8'h00, 1'b0);
        send_text("1");
        send_text("2x");

        for (int p = 0; p < N_PHASES; p++) begin
            write_fraction_enable(p < N_PHASES - 1 ? p[0] : 1'($urandom_range(0, 1)));
            if (p == 2) begin
                s_tvalid <= 1'b0;
                burst_left = 0;
                @(posedge aclk);
                hold_req = 1'b1;
                @(negedge aclk);
            end
            phase_end = n_items + N_RANDOM / N_PHASES;
            while (n_items < phase_end) send_random_number();
        end

        wait_drained();
        if (fail_count == 0 && exp_pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
